>>> src/rtsm_pkg.sv
// ----------------------------------------------------------------------------
// rtsm_pkg
// Shared types, widths and codes for the reverse trie suffix matcher.
// ----------------------------------------------------------------------------
package rtsm_pkg;

	localparam int NODE_COUNT   = 1024;
	localparam int SNIPPET_BITS = 16;

	localparam int IDX_W  = $clog2(NODE_COUNT);
	localparam int FREE_W = $clog2(NODE_COUNT + 1);
	localparam int CHR_W  = 8;
	localparam int ID_W   = 16;
	localparam int ACT_W  = 2;

	localparam logic [FREE_W-1:0] POOL_FULL = FREE_W'(NODE_COUNT);

	localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
	localparam logic [ACT_W-1:0] ACT_MATCH  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

	typedef enum logic [2:0] {
		ST_INSERTED  = 3'd0,
		ST_OVERWROTE = 3'd1,
		ST_NO_MEMORY = 3'd2,
		ST_MATCHED   = 3'd3,
		ST_NO_MATCH  = 3'd4
	} status_t;

	typedef struct packed {
		logic [CHR_W-1:0]        chr;
		logic [IDX_W-1:0]        child;
		logic                    has_child;
		logic [IDX_W-1:0]        sib;
		logic                    has_sib;
		logic                    has_snip;
		logic [SNIPPET_BITS-1:0] snip;
	} node_t;

	localparam int NODE_W = $bits(node_t);

	typedef struct packed {
		logic              re;
		logic              we;
		logic [IDX_W-1:0]  addr;
		logic [NODE_W-1:0] wdata;
	} mem_req_t;

	typedef struct packed {
		logic            done;
		status_t         status;
		logic [ID_W-1:0] snip;
	} result_t;

	// root reads as empty until its first write after reset or a clear
	function automatic node_t node_view(logic [IDX_W-1:0] addr, logic root_valid,
			logic [NODE_W-1:0] rdata);
		node_t n;
		n = node_t'(rdata);
		if (addr == '0 && !root_valid) begin
			n = '0;
		end
		return n;
	endfunction

endpackage

>>> src/rtsm_ram.sv
// ----------------------------------------------------------------------------
// rtsm_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module rtsm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     re,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

>>> src/rtsm_ctrl.sv
// ----------------------------------------------------------------------------
// rtsm_ctrl
// Walk sequencer: reads parent and sibling nodes, allocates and links new
// nodes, attaches snippets and forms the result beat.
// ----------------------------------------------------------------------------
module rtsm_ctrl (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic [rtsm_pkg::ACT_W-1:0]             action,
	input  logic [rtsm_pkg::CHR_W-1:0]             character,
	input  logic                                   first_char,
	input  logic                                   last_char,
	input  logic [rtsm_pkg::ID_W-1:0]              snippet_id,
	output rtsm_pkg::mem_req_t                     mem_req,
	input  logic [rtsm_pkg::NODE_W-1:0]            mem_rdata,
	output rtsm_pkg::result_t                      result
);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_BEGIN = 8'b0000_0010,
		S_PAR   = 8'b0000_0100,
		S_SIB   = 8'b0000_1000,
		S_MISS  = 8'b0001_0000,
		S_LINK  = 8'b0010_0000,
		S_END   = 8'b0100_0000,
		S_SNP   = 8'b1000_0000
	} state_t;

	state_t                               state_q;
	logic [rtsm_pkg::ACT_W-1:0]           act_q;
	logic [rtsm_pkg::CHR_W-1:0]           chr_q;
	logic                                 first_q;
	logic                                 last_q;
	logic [rtsm_pkg::SNIPPET_BITS-1:0]    sid_q;
	logic [rtsm_pkg::IDX_W-1:0]           walk_q;
	logic [rtsm_pkg::IDX_W-1:0]           cur_q;
	logic [rtsm_pkg::FREE_W-1:0]          next_free_q;
	logic                                 best_valid_q;
	logic [rtsm_pkg::SNIPPET_BITS-1:0]    best_q;
	logic                                 failed_q;
	logic                                 root_valid_q;
	logic                                 has_last_q;
	rtsm_pkg::node_t                      par_q;
	rtsm_pkg::node_t                      lent_q;
	rtsm_pkg::result_t                    result_q;

	rtsm_pkg::node_t                      par_view;
	rtsm_pkg::node_t                      sib_node;
	rtsm_pkg::node_t                      walk_view;
	rtsm_pkg::node_t                      fresh_node;
	rtsm_pkg::node_t                      link_node;
	logic [rtsm_pkg::IDX_W-1:0]           fresh_idx;
	logic [rtsm_pkg::IDX_W-1:0]           walk_eff;
	logic                                 failed_eff;

	assign busy   = (state_q != S_IDLE);
	assign result = result_q;

	assign par_view  = rtsm_pkg::node_view(walk_q, root_valid_q, mem_rdata);
	assign walk_view = rtsm_pkg::node_view(walk_q, root_valid_q, mem_rdata);
	assign sib_node  = rtsm_pkg::node_t'(mem_rdata);
	assign fresh_idx = next_free_q[rtsm_pkg::IDX_W-1:0];
	assign walk_eff  = first_q ? '0 : walk_q;
	assign failed_eff = first_q ? 1'b0 : failed_q;

	always_comb begin
		fresh_node     = '0;
		fresh_node.chr = chr_q;
		if (has_last_q) begin
			link_node         = lent_q;
			link_node.sib     = fresh_idx;
			link_node.has_sib = 1'b1;
		end else begin
			link_node           = par_q;
			link_node.child     = fresh_idx;
			link_node.has_child = 1'b1;
		end
	end

	// memory port
	always_comb begin
		mem_req = '0;
		case (state_q)
			S_BEGIN: begin
				mem_req.addr = walk_eff;
				mem_req.re   = (act_q == rtsm_pkg::ACT_INSERT || act_q == rtsm_pkg::ACT_MATCH)
					&& !failed_eff;
			end
			S_PAR: begin
				mem_req.addr = par_view.child;
				mem_req.re   = par_view.has_child;
			end
			S_SIB: begin
				mem_req.addr = sib_node.sib;
				mem_req.re   = (sib_node.chr != chr_q) && sib_node.has_sib;
			end
			S_MISS: begin
				mem_req.addr  = fresh_idx;
				mem_req.wdata = fresh_node;
				mem_req.we    = (act_q == rtsm_pkg::ACT_INSERT) && (next_free_q < rtsm_pkg::POOL_FULL);
			end
			S_LINK: begin
				mem_req.addr  = has_last_q ? cur_q : walk_q;
				mem_req.wdata = link_node;
				mem_req.we    = 1'b1;
			end
			S_END: begin
				mem_req.addr = walk_q;
				mem_req.re   = last_q && (act_q == rtsm_pkg::ACT_INSERT) && !failed_q;
			end
			S_SNP: begin
				mem_req.addr  = walk_q;
				mem_req.wdata = {walk_view.chr, walk_view.child, walk_view.has_child,
					walk_view.sib, walk_view.has_sib, 1'b1, sid_q};
				mem_req.we    = 1'b1;
			end
			default: begin
				mem_req = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			walk_q        <= '0;
			next_free_q   <= rtsm_pkg::FREE_W'(1);
			best_valid_q  <= 1'b0;
			failed_q      <= 1'b0;
			root_valid_q  <= 1'b0;
			has_last_q    <= 1'b0;
			result_q      <= '0;
		end else begin
			result_q.done <= 1'b0;
			if (mem_req.we && mem_req.addr == '0) begin
				root_valid_q <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_BEGIN;
					end
				end
				S_BEGIN: begin
					state_q <= S_IDLE;
					if (act_q == rtsm_pkg::ACT_CLEAR) begin
						next_free_q  <= rtsm_pkg::FREE_W'(1);
						root_valid_q <= 1'b0;
						walk_q       <= '0;
						best_valid_q <= 1'b0;
						failed_q     <= 1'b0;
					end else if (act_q == rtsm_pkg::ACT_INSERT || act_q == rtsm_pkg::ACT_MATCH) begin
						if (first_q) begin
							walk_q       <= '0;
							best_valid_q <= 1'b0;
							failed_q     <= 1'b0;
						end
						state_q <= failed_eff ? S_END : S_PAR;
					end
				end
				S_PAR: begin
					par_q      <= par_view;
					has_last_q <= 1'b0;
					cur_q      <= par_view.child;
					state_q    <= par_view.has_child ? S_SIB : S_MISS;
				end
				S_SIB: begin
					if (sib_node.chr == chr_q) begin
						walk_q <= cur_q;
						if (act_q == rtsm_pkg::ACT_MATCH && sib_node.has_snip) begin
							best_valid_q <= 1'b1;
							best_q       <= sib_node.snip;
						end
						state_q <= S_END;
					end else if (sib_node.has_sib) begin
						cur_q <= sib_node.sib;
					end else begin
						lent_q     <= sib_node;
						has_last_q <= 1'b1;
						state_q    <= S_MISS;
					end
				end
				S_MISS: begin
					if (act_q == rtsm_pkg::ACT_INSERT && next_free_q < rtsm_pkg::POOL_FULL) begin
						state_q <= S_LINK;
					end else begin
						failed_q <= 1'b1;
						state_q  <= S_END;
					end
				end
				S_LINK: begin
					walk_q      <= fresh_idx;
					next_free_q <= next_free_q + rtsm_pkg::FREE_W'(1);
					state_q     <= S_END;
				end
				S_END: begin
					state_q <= S_IDLE;
					if (last_q) begin
						if (act_q == rtsm_pkg::ACT_INSERT && !failed_q) begin
							state_q <= S_SNP;
						end else begin
							result_q.done <= 1'b1;
							if (act_q == rtsm_pkg::ACT_INSERT) begin
								result_q.status <= rtsm_pkg::ST_NO_MEMORY;
								result_q.snip   <= '0;
							end else if (best_valid_q) begin
								result_q.status <= rtsm_pkg::ST_MATCHED;
								result_q.snip   <= rtsm_pkg::ID_W'(best_q);
							end else begin
								result_q.status <= rtsm_pkg::ST_NO_MATCH;
								result_q.snip   <= '0;
							end
							walk_q       <= '0;
							best_valid_q <= 1'b0;
							failed_q     <= 1'b0;
						end
					end
				end
				S_SNP: begin
					result_q.done   <= 1'b1;
					result_q.status <= walk_view.has_snip ? rtsm_pkg::ST_OVERWROTE
						: rtsm_pkg::ST_INSERTED;
					result_q.snip   <= '0;
					walk_q          <= '0;
					best_valid_q    <= 1'b0;
					failed_q        <= 1'b0;
					state_q         <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// command beat capture
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			act_q   <= action;
			chr_q   <= character;
			first_q <= first_char;
			last_q  <= last_char;
			sid_q   <= snippet_id[rtsm_pkg::SNIPPET_BITS-1:0];
		end
	end

endmodule

>>> src/reverse_trie_suffix_matcher_unit.sv
// ----------------------------------------------------------------------------
// reverse_trie_suffix_matcher_unit
// Byte trie in a node RAM; insert steps build reversed triggers, match steps
// follow ring bytes newest first and report the longest matching snippet.
//
//   channel   handshake            fields
//   command   start / busy         action, character, first_char, last_char,
//                                  snippet_id
//   result    done (one cycle)     status, snippet_id_res
//
// A step reads sibling nodes from the node RAM one at a time; a missing child
// adds the miss state, a new node the link state and an insert's snippet the
// snippet state. A step skipped after a failure jumps to the end; clear
// and ignored actions go idle. done cannot be held off by the receiver.
// Reset empties the trie at once: the root is held empty by a flag, so no
// clearing pass runs. busy is high from the accepted beat until the step ends.
// ----------------------------------------------------------------------------
module reverse_trie_suffix_matcher_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [rtsm_pkg::ACT_W-1:0] action,
	input  logic [rtsm_pkg::CHR_W-1:0] character,
	input  logic                       first_char,
	input  logic                       last_char,
	input  logic [rtsm_pkg::ID_W-1:0]  snippet_id,
	output logic                       done,
	output logic [2:0]                 status,
	output logic [rtsm_pkg::ID_W-1:0]  snippet_id_res
);

	rtsm_pkg::mem_req_t              mem_req;
	logic [rtsm_pkg::NODE_W-1:0]     mem_rdata;
	rtsm_pkg::result_t               result;

	rtsm_ram #(
		.WIDTH(rtsm_pkg::NODE_W),
		.DEPTH(rtsm_pkg::NODE_COUNT)
	) u_node_ram (
		.clk   (clk),
		.re    (mem_req.re),
		.we    (mem_req.we),
		.addr  (mem_req.addr),
		.wdata (mem_req.wdata),
		.rdata (mem_rdata)
	);

	rtsm_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.action     (action),
		.character  (character),
		.first_char (first_char),
		.last_char  (last_char),
		.snippet_id (snippet_id),
		.mem_req    (mem_req),
		.mem_rdata  (mem_rdata),
		.result     (result)
	);

	assign done           = result.done;
	assign status         = result.status;
	assign snippet_id_res = result.snip;

endmodule

>>> verif/tb_reverse_trie_suffix_matcher_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_reverse_trie_suffix_matcher_unit
// Drives insert, match, clear and ignored steps into the trie matcher through
// the start / busy port. A model of the node pool runs alongside and predicts
// each status and snippet beat. Stimulus starts with hand-picked steps. It then
// runs random trigger inserts, ring matches and stray steps, fills the pool until inserts
// fail, and ends with another random burst. Gaps between steps are random.
// ----------------------------------------------------------------------------
module tb_reverse_trie_suffix_matcher_unit;

	localparam logic [rtsm_pkg::ACT_W-1:0] ACT_IGNORED = 2'd3;
	localparam int KEY_SLOTS  = 256;
	localparam int KEY_BYTES  = 64;
	localparam int QUIET_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 300;

	typedef struct {
		logic [rtsm_pkg::ACT_W-1:0] act;
		logic [rtsm_pkg::CHR_W-1:0] chr;
		logic                       first;
		logic                       last;
		logic [rtsm_pkg::ID_W-1:0]  sid;
		int                         gap;
		bit                         drain;
	} trie_step_t;

	typedef struct {
		rtsm_pkg::status_t         status;
		logic [rtsm_pkg::ID_W-1:0] snip;
	} trie_reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [rtsm_pkg::ACT_W-1:0] action = rtsm_pkg::ACT_INSERT;
	logic [rtsm_pkg::CHR_W-1:0] character = '0;
	logic first_char = 1'b0;
	logic last_char = 1'b0;
	logic [rtsm_pkg::ID_W-1:0] snippet_id = '0;
	logic done;
	logic [2:0] status;
	logic [rtsm_pkg::ID_W-1:0] snippet_id_res;

	reverse_trie_suffix_matcher_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.action         (action),
		.character      (character),
		.first_char     (first_char),
		.last_char      (last_char),
		.snippet_id     (snippet_id),
		.done           (done),
		.status         (status),
		.snippet_id_res (snippet_id_res)
	);

	always #2 clk = ~clk;

	// node pool copy
	logic [rtsm_pkg::CHR_W-1:0]        trie_chr      [rtsm_pkg::NODE_COUNT];
	int                                trie_child    [rtsm_pkg::NODE_COUNT];
	int                                trie_sib      [rtsm_pkg::NODE_COUNT];
	bit                                trie_has_child[rtsm_pkg::NODE_COUNT];
	bit                                trie_has_sib  [rtsm_pkg::NODE_COUNT];
	bit                                trie_has_snip [rtsm_pkg::NODE_COUNT];
	logic [rtsm_pkg::SNIPPET_BITS-1:0] trie_snip     [rtsm_pkg::NODE_COUNT];
	int                                alloc_ptr;
	int                                cursor;
	bit                                best_hit;
	logic [rtsm_pkg::SNIPPET_BITS-1:0] best_id;
	bit                                walk_dead;

	trie_step_t  steps_to_send[$];
	trie_reply_t replies_due[$];
	trie_step_t  cur_step;
	int          gap_left = 0;
	int          steps_sent = 0;
	int          step_total = 0;
	int          mismatches = 0;
	int          quiet_cycles = 0;

	// generator state
	logic [rtsm_pkg::CHR_W-1:0] key_bytes[KEY_SLOTS][KEY_BYTES];
	int                         key_len[KEY_SLOTS];
	int                         key_next = 0;
	bit                         calm = 1'b0;
	bit                         hold_next = 1'b0;

	function automatic void seq_restart();
		cursor    = 0;
		best_hit  = 1'b0;
		best_id   = '0;
		walk_dead = 1'b0;
	endfunction

	function automatic void trie_clear();
		for (int i = 0; i < rtsm_pkg::NODE_COUNT; i++) begin
			trie_chr[i]       = '0;
			trie_child[i]     = 0;
			trie_sib[i]       = 0;
			trie_has_child[i] = 1'b0;
			trie_has_sib[i]   = 1'b0;
			trie_has_snip[i]  = 1'b0;
			trie_snip[i]      = '0;
		end
		alloc_ptr = 1;
		seq_restart();
	endfunction

	// walks the child list of parent; tail is the last sibling on a miss
	function automatic bit child_lookup(input int parent,
			input logic [rtsm_pkg::CHR_W-1:0] c,
			output int hit, output int tail, output bit has_tail);
		int cur;
		int guard;
		hit = 0;
		tail = 0;
		has_tail = 1'b0;
		if (!trie_has_child[parent]) return 1'b0;
		cur = trie_child[parent];
		guard = 0;
		while (guard < rtsm_pkg::NODE_COUNT) begin
			if (trie_chr[cur] == c) begin
				hit = cur;
				return 1'b1;
			end
			tail = cur;
			has_tail = 1'b1;
			if (!trie_has_sib[cur]) return 1'b0;
			cur = trie_sib[cur];
			guard++;
		end
		return 1'b0;
	endfunction

	function automatic void trie_apply(input trie_step_t s);
		int hit;
		int tail;
		int fresh;
		bit has_tail;
		trie_reply_t r;
		if (s.act == rtsm_pkg::ACT_CLEAR) begin
			trie_clear();
			return;
		end
		if (s.act == ACT_IGNORED) return;
		if (s.first) seq_restart();
		r.snip = '0;
		if (s.act == rtsm_pkg::ACT_INSERT) begin
			if (!walk_dead) begin
				if (child_lookup(cursor, s.chr, hit, tail, has_tail)) begin
					cursor = hit;
				end else if (alloc_ptr >= rtsm_pkg::NODE_COUNT) begin
					walk_dead = 1'b1;
				end else begin
					fresh = alloc_ptr;
					alloc_ptr++;
					trie_chr[fresh]       = s.chr;
					trie_child[fresh]     = 0;
					trie_sib[fresh]       = 0;
					trie_has_child[fresh] = 1'b0;
					trie_has_sib[fresh]   = 1'b0;
					trie_has_snip[fresh]  = 1'b0;
					trie_snip[fresh]      = '0;
					if (has_tail) begin
						trie_sib[tail]     = fresh;
						trie_has_sib[tail] = 1'b1;
					end else begin
						trie_child[cursor]     = fresh;
						trie_has_child[cursor] = 1'b1;
					end
					cursor = fresh;
				end
			end
			if (!s.last) return;
			if (walk_dead) begin
				r.status = rtsm_pkg::ST_NO_MEMORY;
			end else begin
				r.status = trie_has_snip[cursor] ? rtsm_pkg::ST_OVERWROTE
					: rtsm_pkg::ST_INSERTED;
				trie_has_snip[cursor] = 1'b1;
				trie_snip[cursor]     = s.sid[rtsm_pkg::SNIPPET_BITS-1:0];
			end
		end else begin
			if (!walk_dead) begin
				if (!child_lookup(cursor, s.chr, hit, tail, has_tail)) begin
					walk_dead = 1'b1;
				end else begin
					cursor = hit;
					if (trie_has_snip[hit]) begin
						best_hit = 1'b1;
						best_id  = trie_snip[hit];
					end
				end
			end
			if (!s.last) return;
			if (best_hit) begin
				r.status = rtsm_pkg::ST_MATCHED;
				r.snip   = rtsm_pkg::ID_W'(best_id);
			end else begin
				r.status = rtsm_pkg::ST_NO_MATCH;
			end
		end
		replies_due.push_back(r);
		seq_restart();
	endfunction

	// driver
	always @(posedge clk) begin
		logic present;
		present = start;
		if (arst_n) begin
			if (start && !busy) begin
				trie_apply(cur_step);
				steps_sent++;
				present = 1'b0;
				gap_left = (steps_to_send.size() > 0) ? steps_to_send[0].gap : 0;
			end
			if (!present && steps_to_send.size() > 0) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (!steps_to_send[0].drain || (replies_due.size() == 0 && !done)) begin
					cur_step = steps_to_send.pop_front();
					present = 1'b1;
					action     <= cur_step.act;
					character  <= cur_step.chr;
					first_char <= cur_step.first;
					last_char  <= cur_step.last;
					snippet_id <= cur_step.sid;
				end
			end
		end
		start <= present;
	end

	// monitor and watchdog
	always @(posedge clk) begin
		trie_reply_t want;
		if (arst_n) begin
			if ((start && !busy) || done) quiet_cycles = 0;
			else quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
				$display("FAIL");
				$finish;
			end
			if (done) begin
				if (replies_due.size() == 0) begin
					mismatches++;
					$display("%0t: result with none expected, got status %0d snippet %h",
						$time, status, snippet_id_res);
				end else begin
					want = replies_due.pop_front();
					if (status !== want.status) begin
						mismatches++;
						$display("%0t: status expected %0d got %0d", $time, want.status, status);
					end
					if (snippet_id_res !== want.snip) begin
						mismatches++;
						$display("%0t: snippet expected %h got %h", $time, want.snip,
							snippet_id_res);
					end
				end
			end
		end
	end

	task automatic add_step(input logic [rtsm_pkg::ACT_W-1:0] act,
			input logic [rtsm_pkg::CHR_W-1:0] c,
			input bit f, input bit l, input logic [rtsm_pkg::ID_W-1:0] sid);
		trie_step_t s;
		s.act   = act;
		s.chr   = c;
		s.first = f;
		s.last  = l;
		s.sid   = sid;
		s.gap   = calm ? 0 : $urandom_range(0, 8);
		s.drain = hold_next;
		hold_next = 1'b0;
		steps_to_send.push_back(s);
	endtask

	function automatic int key_pool();
		return (key_next < KEY_SLOTS) ? key_next : KEY_SLOTS;
	endfunction

	task automatic gen_clear();
		add_step(rtsm_pkg::ACT_CLEAR, rtsm_pkg::CHR_W'($urandom), $urandom_range(0, 1) != 0,
			$urandom_range(0, 1) != 0, rtsm_pkg::ID_W'($urandom));
		key_next = 0;
	endtask

	// trigger bytes go in last-first; reuse replays a known trigger
	task automatic gen_insert(input int len, input int span, input bit reuse);
		int slot;
		bit lead;
		logic [rtsm_pkg::CHR_W-1:0] b;
		logic [rtsm_pkg::ID_W-1:0] sid;
		if (reuse && key_next > 0) begin
			slot = $urandom_range(0, key_pool() - 1);
			len = key_len[slot];
		end else begin
			reuse = 1'b0;
			slot = key_next % KEY_SLOTS;
			key_next++;
			key_len[slot] = len;
		end
		sid = rtsm_pkg::ID_W'($urandom);
		lead = $urandom_range(0, 19) != 0;
		for (int i = 0; i < len; i++) begin
			if (reuse) begin
				b = key_bytes[slot][i];
			end else begin
				b = rtsm_pkg::CHR_W'($urandom_range(0, span));
				key_bytes[slot][i] = b;
			end
			add_step(rtsm_pkg::ACT_INSERT, b, (i == 0) && lead, i == len - 1,
				(i == len - 1) ? sid : rtsm_pkg::ID_W'($urandom));
		end
	endtask

	// ring bytes newest first: a known trigger, maybe cut or damaged, plus a few more
	task automatic gen_match();
		logic [rtsm_pkg::CHR_W-1:0] ring[KEY_BYTES + 8];
		int n;
		int slot;
		int extra;
		bit lead;
		n = 0;
		if (key_next > 0 && $urandom_range(0, 4) != 0) begin
			slot = $urandom_range(0, key_pool() - 1);
			n = key_len[slot];
			for (int i = 0; i < n; i++) ring[i] = key_bytes[slot][i];
			if ($urandom_range(0, 3) == 0) n = $urandom_range(1, n);
			if ($urandom_range(0, 5) == 0)
				ring[$urandom_range(0, n - 1)] = rtsm_pkg::CHR_W'($urandom);
		end
		extra = (n == 0) ? $urandom_range(1, 5) : $urandom_range(0, 3);
		repeat (extra) begin
			ring[n] = rtsm_pkg::CHR_W'($urandom);
			n++;
		end
		lead = $urandom_range(0, 19) != 0;
		for (int i = 0; i < n; i++)
			add_step(rtsm_pkg::ACT_MATCH, ring[i], (i == 0) && lead, i == n - 1,
				rtsm_pkg::ID_W'($urandom));
	endtask

	task automatic mixed_burst(input int goal);
		int stop;
		int pick;
		int span;
		stop = steps_to_send.size() + goal;
		while (steps_to_send.size() < stop) begin
			if ($urandom_range(0, 7) == 0) calm = !calm;
			case ($urandom_range(0, 2))
				0: span = 3;
				1: span = 15;
				default: span = 255;
			endcase
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				gen_insert($urandom_range(1, 6), span, $urandom_range(0, 6) == 0);
			end else if (pick < 80) begin
				gen_match();
			end else if (pick < 98) begin
				add_step(($urandom_range(0, 3) == 0) ? ACT_IGNORED :
					(($urandom_range(0, 1) != 0) ? rtsm_pkg::ACT_MATCH : rtsm_pkg::ACT_INSERT),
					rtsm_pkg::CHR_W'($urandom), $urandom_range(0, 1) != 0,
					$urandom_range(0, 1) != 0, rtsm_pkg::ID_W'($urandom));
			end else begin
				gen_clear();
			end
		end
	endtask

	initial begin
		trie_clear();

		// directed steps
		add_step(rtsm_pkg::ACT_MATCH,  8'h00, 1'b1, 1'b1, 16'h0000);
		add_step(rtsm_pkg::ACT_INSERT, 8'hFF, 1'b1, 1'b0, 16'h0000);
		add_step(rtsm_pkg::ACT_INSERT, 8'h00, 1'b0, 1'b1, 16'hFFFF);
		add_step(rtsm_pkg::ACT_INSERT, 8'hFF, 1'b1, 1'b0, 16'hFFFF);
		add_step(rtsm_pkg::ACT_INSERT, 8'h00, 1'b0, 1'b1, 16'h0000);
		add_step(rtsm_pkg::ACT_INSERT, 8'h80, 1'b1, 1'b1, 16'h5A5A);
		add_step(rtsm_pkg::ACT_MATCH,  8'hFF, 1'b1, 1'b0, 16'h0000);
		add_step(rtsm_pkg::ACT_MATCH,  8'h00, 1'b0, 1'b0, 16'h0000);
		add_step(rtsm_pkg::ACT_MATCH,  8'h80, 1'b0, 1'b1, 16'h0000);
		add_step(rtsm_pkg::ACT_MATCH,  8'h80, 1'b1, 1'b1, 16'h0000);
		add_step(rtsm_pkg::ACT_MATCH,  8'h01, 1'b1, 1'b0, 16'h0000);
		add_step(rtsm_pkg::ACT_MATCH,  8'h80, 1'b0, 1'b1, 16'h0000);
		// insert walk carried on by a match step
		add_step(rtsm_pkg::ACT_INSERT, 8'hFF, 1'b1, 1'b0, 16'h0000);
		add_step(rtsm_pkg::ACT_MATCH,  8'h00, 1'b0, 1'b1, 16'h0000);
		add_step(rtsm_pkg::ACT_MATCH,  8'h80, 1'b0, 1'b1, 16'h0000);
		add_step(ACT_IGNORED,          8'h55, 1'b1, 1'b1, 16'hAAAA);
		add_step(rtsm_pkg::ACT_CLEAR,  8'hAA, 1'b1, 1'b1, 16'h5555);
		add_step(rtsm_pkg::ACT_MATCH,  8'hFF, 1'b1, 1'b1, 16'h0000);
		add_step(rtsm_pkg::ACT_INSERT, 8'hFF, 1'b1, 1'b0, 16'h1234);
		add_step(rtsm_pkg::ACT_CLEAR,  8'h00, 1'b0, 1'b0, 16'h0000);
		add_step(rtsm_pkg::ACT_INSERT, 8'h00, 1'b0, 1'b1, 16'h8001);

		mixed_burst(150);

		// fill the pool until inserts run out of nodes
		hold_next = 1'b1;
		gen_clear();
		for (int k = 0; k < 18; k++) gen_insert(60, 255, 1'b0);
		repeat (40) begin
			case ($urandom_range(0, 2))
				0: gen_match();
				1: gen_insert($urandom_range(1, 4), 255, 1'b0);
				default: gen_insert(0, 0, 1'b1);
			endcase
		end

		hold_next = 1'b1;
		gen_clear();
		mixed_burst(80);
		step_total = steps_to_send.size();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (steps_sent != step_total) @(posedge clk);
		while (replies_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && replies_due.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
